// ===== rtl/u8sd_pkg.sv =====
`default_nettype none

package u8sd_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned PHASE_W = 4;

    // Default saturation limit for the byte and code point counters
    localparam int unsigned MAX_BYTES_DEFAULT = 65536;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_POINT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BAD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END_OK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END_ERR = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CP_W-1:0]   code_point;
        logic [POS_W-1:0]  position;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/u8sd_byte_if.sv =====
`default_nettype none

interface u8sd_byte_if;
    logic                           valid;
    logic                           ready;
    logic [u8sd_pkg::BYTE_W-1:0]    data_byte;
    logic                           end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== rtl/u8sd_result_if.sv =====
`default_nettype none

interface u8sd_result_if;
    logic                           valid;
    logic                           ready;
    logic [u8sd_pkg::KIND_W-1:0]    kind;
    logic [u8sd_pkg::CP_W-1:0]      code_point;
    logic [u8sd_pkg::POS_W-1:0]     position;
    logic                           last;

    modport source (output valid, output kind, output code_point, output position,
                    output last, input ready);
    modport sink   (input valid, input kind, input code_point, input position,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8_stream_decoder.sv =====
`default_nettype none

// Channel    Dir  Payload                                          Handshake
// i_byte_if  in   data_byte[7:0], end_of_string                    valid/ready
// o_res_if   out  kind[1:0], code_point[20:0], position[16:0], last valid/ready
//
// One byte per clock while the buffer has room. A byte is decoded in the cycle it
// is taken and its results appear on o_res_if from the next cycle, out of a two-entry
// result buffer. A byte that yields two results (its own plus the end-of-string
// result) fills both entries, so the next byte waits while the head drains.
// Input is ready when the buffer is empty or its one entry leaves in this cycle;
// downstream stalls hold the buffer. Synchronous reset empties it, clears the decoder.

module utf8_stream_decoder #(
    parameter int unsigned MAX_BYTES = u8sd_pkg::MAX_BYTES_DEFAULT
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    u8sd_byte_if.sink        i_byte_if,
    u8sd_result_if.source    o_res_if
);

    localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);

    // Sequence phases
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_WRONG  = 4'd0;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_BEGIN  = 4'd1;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_ONE    = 4'd2;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_TWO1   = 4'd3;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_TWO2   = 4'd4;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_THREE1 = 4'd5;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_THREE2 = 4'd6;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_THREE3 = 4'd7;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_FOUR1  = 4'd8;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_FOUR2  = 4'd9;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_FOUR3  = 4'd10;
    localparam logic [u8sd_pkg::PHASE_W-1:0] PH_FOUR4  = 4'd11;

    // Decoder state
    logic [u8sd_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [u8sd_pkg::CP_W-1:0]    r_partial, n_partial;
    logic [CNT_W-1:0]             r_points, n_points;
    logic [CNT_W-1:0]             r_index, n_index;
    logic                         r_error, n_error;

    // Result buffer: entry 0 is the head
    u8sd_pkg::t_result            r_slot0, n_slot0;
    u8sd_pkg::t_result            r_slot1, n_slot1;
    logic [1:0]                   r_cnt, n_cnt;

    logic                         in_take;
    logic                         out_take;

    // Per-byte decode outputs
    u8sd_pkg::t_result            own_res;
    logic                         own_vld;
    u8sd_pkg::t_result            end_res;
    logic [u8sd_pkg::PHASE_W-1:0] cont_phase;
    logic                         cont_done;
    logic [u8sd_pkg::CP_W-1:0]    shifted;
    logic [CNT_W-1:0]             points_upd;
    logic [u8sd_pkg::BYTE_W-1:0]  b;

    assign b        = i_byte_if.data_byte;
    assign out_take = o_res_if.valid & o_res_if.ready;
    assign in_take  = i_byte_if.valid & i_byte_if.ready;

    // Room for two results once the head leaves
    assign i_byte_if.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_res_if.ready);

    assign o_res_if.valid      = (r_cnt != 2'd0);
    assign o_res_if.kind       = r_slot0.kind;
    assign o_res_if.code_point = r_slot0.code_point;
    assign o_res_if.position   = r_slot0.position;
    assign o_res_if.last       = r_slot0.last;

    assign shifted = {r_partial[u8sd_pkg::CP_W-7:0], b[5:0]};

    // Continuation byte: next phase, and whether it closes the sequence
    always_comb begin
        cont_phase = PH_WRONG;
        cont_done  = 1'b0;
        case (r_phase)
            PH_TWO1: begin
                cont_phase = PH_TWO2;
                cont_done  = 1'b1;
            end
            PH_THREE1: begin
                cont_phase = PH_THREE2;
            end
            PH_THREE2: begin
                cont_phase = PH_THREE3;
                cont_done  = 1'b1;
            end
            PH_FOUR1: begin
                cont_phase = PH_FOUR2;
            end
            PH_FOUR2: begin
                cont_phase = PH_FOUR3;
            end
            PH_FOUR3: begin
                cont_phase = PH_FOUR4;
                cont_done  = 1'b1;
            end
            default: begin
                cont_phase = PH_WRONG;
                cont_done  = 1'b0;
            end
        endcase
    end

    assign points_upd = (r_points < CNT_MAX) ? r_points + 1'b1 : r_points;

    // Byte decode
    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        n_points  = r_points;
        n_error   = r_error;
        n_index   = (r_index < CNT_MAX) ? r_index + 1'b1 : r_index;
        own_vld   = 1'b0;
        own_res   = '0;
        own_res.kind = u8sd_pkg::KIND_POINT;

        if (!r_error) begin
            if (b[7] == 1'b0) begin
                // ASCII: emits at once
                n_phase   = PH_ONE;
                n_partial = {{(u8sd_pkg::CP_W-7){1'b0}}, b[6:0]};
                own_vld   = 1'b1;
                own_res.code_point = {{(u8sd_pkg::CP_W-7){1'b0}}, b[6:0]};
                n_points  = points_upd;
            end else if (b[7:5] == 3'b110) begin
                n_phase   = PH_TWO1;
                n_partial = {{(u8sd_pkg::CP_W-5){1'b0}}, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                n_phase   = PH_THREE1;
                n_partial = {{(u8sd_pkg::CP_W-4){1'b0}}, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                n_phase   = PH_FOUR1;
                n_partial = {{(u8sd_pkg::CP_W-3){1'b0}}, b[2:0]};
            end else if (b[7:6] == 2'b10) begin
                if (cont_phase == PH_WRONG) begin
                    // misplaced continuation byte
                    n_phase          = PH_WRONG;
                    n_error          = 1'b1;
                    own_vld          = 1'b1;
                    own_res.kind     = u8sd_pkg::KIND_BAD;
                    own_res.position = u8sd_pkg::POS_W'(r_index);
                end else begin
                    n_phase   = cont_phase;
                    n_partial = shifted;
                    if (cont_done) begin
                        own_vld            = 1'b1;
                        own_res.code_point = shifted;
                        n_points           = points_upd;
                    end
                end
            end
            // 0xF8..0xFF fall through: only the index moves
        end

        own_res.last = ~i_byte_if.end_of_string;
        own_res.last = own_res.last ? 1'b0 : 1'b0;

        end_res      = '0;
        end_res.last = 1'b1;
        if (n_error) begin
            end_res.kind = u8sd_pkg::KIND_END_ERR;
        end else begin
            end_res.kind     = u8sd_pkg::KIND_END_OK;
            end_res.position = u8sd_pkg::POS_W'(n_points);
        end

        if (i_byte_if.end_of_string) begin
            n_phase   = PH_BEGIN;
            n_partial = '0;
            n_points  = '0;
            n_index   = '0;
            n_error   = 1'b0;
        end else begin
            own_res.last = 1'b1;
        end
    end

    // Result buffer update
    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = r_cnt;
        if (in_take) begin
            // buffer is empty after this cycle's pop, so results start at the head
            if (own_vld) begin
                n_slot0 = own_res;
                n_slot1 = end_res;
                n_cnt   = i_byte_if.end_of_string ? 2'd2 : 2'd1;
            end else begin
                n_slot0 = end_res;
                n_cnt   = i_byte_if.end_of_string ? 2'd1 : 2'd0;
            end
        end else if (out_take) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_BEGIN;
            r_partial <= '0;
            r_points  <= '0;
            r_index   <= '0;
            r_error   <= 1'b0;
            r_cnt     <= 2'd0;
        end else begin
            if (in_take) begin
                r_phase   <= n_phase;
                r_partial <= n_partial;
                r_points  <= n_points;
                r_index   <= n_index;
                r_error   <= n_error;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

`default_nettype wire

// ===== tb/u8sd_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the decoder, keeps a byte-level decoder model
// and compares every result transaction with the oldest expected one.
module u8sd_checker #(
    parameter int unsigned MAX_BYTES = u8sd_pkg::MAX_BYTES_DEFAULT
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    u8sd_byte_if    i_byte_mon,
    u8sd_result_if  i_res_mon,
    output int      o_fail_count,
    output int      o_pending
);
    import u8sd_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        SEQ_WRONG, SEQ_BEGIN, SEQ_ONE,
        SEQ_TWO1, SEQ_TWO2,
        SEQ_THREE1, SEQ_THREE2, SEQ_THREE3,
        SEQ_FOUR1, SEQ_FOUR2, SEQ_FOUR3, SEQ_FOUR4
    } t_seq;

    t_seq              seq;
    logic [CP_W-1:0]   partial;
    logic [POS_W-1:0]  point_cnt;
    logic [POS_W-1:0]  byte_idx;
    logic              err_seen;
    t_result           pending_results[$];

    function automatic t_result make_result(logic [KIND_W-1:0] kind,
                                            logic [CP_W-1:0] cp,
                                            logic [POS_W-1:0] pos);
        t_result r;
        r.kind       = kind;
        r.code_point = cp;
        r.position   = pos;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic void clear_decoder();
        seq       = SEQ_BEGIN;
        partial   = '0;
        point_cnt = '0;
        byte_idx  = '0;
        err_seen  = 1'b0;
    endfunction

    function automatic void count_point();
        pending_results.push_back(make_result(KIND_POINT, partial, '0));
        if (point_cnt < MAX_BYTES)
            point_cnt++;
    endfunction

    // Updates the model with one byte and queues the results it causes.
    function automatic void decode_byte(logic [BYTE_W-1:0] b, logic eos);
        t_seq nxt;
        logic done;
        int   first;
        first = pending_results.size();
        nxt   = SEQ_WRONG;
        done  = 1'b0;
        if (!err_seen) begin
            casez (b)
                8'b0???????: begin
                    seq     = SEQ_ONE;
                    partial = CP_W'(b[6:0]);
                    count_point();
                end
                8'b110?????: begin
                    seq     = SEQ_TWO1;
                    partial = CP_W'(b[4:0]);
                end
                8'b1110????: begin
                    seq     = SEQ_THREE1;
                    partial = CP_W'(b[3:0]);
                end
                8'b11110???: begin
                    seq     = SEQ_FOUR1;
                    partial = CP_W'(b[2:0]);
                end
                8'b10??????: begin
                    case (seq)
                        SEQ_TWO1:   begin nxt = SEQ_TWO2;   done = 1'b1; end
                        SEQ_THREE1: begin nxt = SEQ_THREE2; end
                        SEQ_THREE2: begin nxt = SEQ_THREE3; done = 1'b1; end
                        SEQ_FOUR1:  begin nxt = SEQ_FOUR2;  end
                        SEQ_FOUR2:  begin nxt = SEQ_FOUR3;  end
                        SEQ_FOUR3:  begin nxt = SEQ_FOUR4;  done = 1'b1; end
                        default:    begin nxt = SEQ_WRONG;  end
                    endcase
                    if (nxt == SEQ_WRONG) begin
                        seq      = SEQ_WRONG;
                        err_seen = 1'b1;
                        pending_results.push_back(make_result(KIND_BAD, '0, byte_idx));
                    end else begin
                        seq     = nxt;
                        partial = {partial[CP_W-7:0], b[5:0]};
                        if (done)
                            count_point();
                    end
                end
                default: ;  // 0xF8..0xFF: no effect besides the index
            endcase
        end

        if (byte_idx < MAX_BYTES)
            byte_idx++;

        if (eos) begin
            if (err_seen)
                pending_results.push_back(make_result(KIND_END_ERR, '0, '0));
            else
                pending_results.push_back(make_result(KIND_END_OK, '0, point_cnt));
            clear_decoder();
        end

        if (pending_results.size() > first)
            pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        int      errs;
        t_result want;
        errs = 0;
        if (!i_rst_n) begin
            clear_decoder();
            pending_results.delete();
            o_fail_count <= 0;
        end else begin
            // a result leaving now belongs to an earlier byte, so check first
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $error("kind: expected none, got %0d", i_res_mon.kind);
                    errs++;
                end else begin
                    want = pending_results.pop_front();
                    errs += field_diff("kind", want.kind, i_res_mon.kind);
                    errs += field_diff("code_point", want.code_point, i_res_mon.code_point);
                    errs += field_diff("position", want.position, i_res_mon.position);
                    errs += field_diff("last", want.last, i_res_mon.last);
                end
            end
            if (i_byte_mon.valid && i_byte_mon.ready)
                decode_byte(i_byte_mon.data_byte, i_byte_mon.end_of_string);
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= pending_results.size();
    end

endmodule

// ===== tb/tb_utf8_stream_decoder.sv =====
`timescale 1ns / 100ps

module tb_utf8_stream_decoder;
    import u8sd_pkg::*;

    // Small saturation limit so that long strings reach the counter ceiling.
    localparam int unsigned STR_LIMIT   = 32;
    localparam int          PHASE_BYTES = 250;     // random bytes per idle phase
    localparam int          CYCLE_LIMIT = 200000;  // far above the slowest legal run
    localparam int          DRAIN       = 10;      // cycles to catch stray results

    // Directed bytes, {end_of_string, data_byte}.
    localparam int          N_DIRECTED  = 25;
    localparam logic [8:0]  DIRECTED [N_DIRECTED] = '{
        9'h000, 9'h07F,                  // lowest and highest single-byte values
        9'h0C2, 9'h080,                  // two-byte sequence
        9'h0EF, 9'h0BF, 9'h0BF,          // three-byte sequence, all payload ones
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // full four-byte sequence
        9'h0F8, 9'h0FF,                  // ignored bytes, only the index moves
        9'h0E2, 9'h082, 9'h141,          // lead cuts off an open sequence; ends string
        9'h0F0, 9'h190,                  // sequence still open on the end byte
        9'h0C0, 9'h180,                  // overlong form decodes as is
        9'h080, 9'h041, 9'h1BF,          // stray continuation, rest ignored
        9'h041, 9'h1BF                   // continuation after a complete point, on end
    };

    // Idle percentages per phase: none, sender, receiver, both.
    localparam int SEND_IDLE [4] = '{0, 64, 0, 25};
    localparam int RECV_IDLE [4] = '{0, 0, 64, 25};

    logic i_clk;
    logic i_rst_n;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   fail_count;
    int   pending;
    int   sent;

    logic [BYTE_W-1:0] str_q[$];  // bytes of the string being built

    u8sd_byte_if   byte_ch ();
    u8sd_result_if res_ch ();

    utf8_stream_decoder #(
        .MAX_BYTES (STR_LIMIT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_if (byte_ch),
        .o_res_if  (res_ch)
    );

    u8sd_checker #(
        .MAX_BYTES (STR_LIMIT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_mon   (byte_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the decoder hangs or never drains.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: a fresh coin toss every cycle.
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One byte transaction. Random gaps first, then valid stays up until the
    // decoder takes it; back-to-back calls that draw no gap keep valid high with no dip.
    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_string <= eos;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        return 8'h80 | (8'($urandom) & 8'h3F);
    endfunction

    // Well-formed code point of random length and payload.
    function automatic void add_point();
        logic [CP_W-1:0] cp;
        cp = CP_W'($urandom);
        case ($urandom_range(3))
            0: str_q.push_back({1'b0, cp[6:0]});
            1: begin
                str_q.push_back({3'b110, cp[10:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end
            2: begin
                str_q.push_back({4'b1110, cp[15:12]});
                str_q.push_back({2'b10, cp[11:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                str_q.push_back({5'b11110, cp[20:18]});
                str_q.push_back({2'b10, cp[17:12]});
                str_q.push_back({2'b10, cp[11:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Broken input: stray continuation, ignored byte, truncated sequence,
    // or any byte at all.
    function automatic void add_noise();
        logic [BYTE_W-1:0] rnd;
        int                len;
        rnd = 8'($urandom);
        len = $urandom_range(2, 4);
        case ($urandom_range(3))
            0: str_q.push_back(cont_byte());
            1: str_q.push_back(8'hF8 | (rnd & 8'h07));
            2: begin
                if (len == 2)
                    str_q.push_back({3'b110, rnd[4:0]});
                else if (len == 3)
                    str_q.push_back({4'b1110, rnd[3:0]});
                else
                    str_q.push_back({5'b11110, rnd[2:0]});
                repeat ($urandom_range(0, len - 2)) str_q.push_back(cont_byte());
            end
            default: str_q.push_back(rnd);
        endcase
    endfunction

    // Mostly short strings; one in twenty long enough to saturate counters.
    function automatic void build_string();
        int n;
        str_q.delete();
        n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        repeat (n) begin
            if ($urandom_range(99) < 8)
                add_noise();
            else
                add_point();
        end
    endfunction

    initial begin
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = '0;
        byte_ch.end_of_string = 1'b0;
        res_ch.ready          = 1'b0;
        i_rst_n               = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes, no idling.
        for (int i = 0; i < N_DIRECTED; i++)
            put_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        // Random strings under each idle pattern. A string is always sent
        // whole, so phases switch on a string boundary.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            recv_idle_pct = RECV_IDLE[ph];
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_string();
                foreach (str_q[i])
                    put_byte(str_q[i], i == str_q.size() - 1);
                sent += str_q.size();
            end
        end

        // A pause for the checker's count to catch up with the last byte,
        // then wait for every expected result, then a short drain.
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== utf8_stream_decoder.f =====
rtl/u8sd_pkg.sv
rtl/u8sd_byte_if.sv
rtl/u8sd_result_if.sv
rtl/utf8_stream_decoder.sv
tb/u8sd_checker.sv
tb/tb_utf8_stream_decoder.sv
